FILE: rtl/assert_macros.svh
// Assertion macros shared by the envelope generator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define BPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define BPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bpe_pkg.sv
// Types and constants of the breakpoint envelope generator.
// No dependencies; used by the other files but bpe_div and assert_macros.svh.
package bpe_pkg;

    localparam int LEVEL_W     = 24;
    localparam int TIME_W      = 17;
    localparam int COUNT_W     = 5;
    localparam int SLOPE_W     = 41;
    localparam int SLOPE_MAG_W = 40;
    localparam int PROD_W      = 42;

    localparam logic [TIME_W-1:0] TIME_ONE = 17'h10000;
    localparam logic [PROD_W-1:0] PRODUCT_LIMIT = 42'h200_0000_0000;

    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 24'sh7FFFFF;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 24'sh800000;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_NEXT  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [1:0] MODE_EQUAL    = 2'd0;
    localparam logic [1:0] MODE_SLOWDOWN = 2'd1;
    localparam logic [1:0] MODE_CENTERED = 2'd2;
    localparam logic [1:0] MODE_STORED   = 2'd3;

    localparam logic REG_POINT_COUNT = 1'b0;
    localparam logic REG_SPACING     = 1'b1;

    typedef struct packed {
        logic [1:0]                operation;
        logic [3:0]                point_index;
        logic [TIME_W-1:0]         point_time;
        logic signed [LEVEL_W-1:0] point_value;
        logic [23:0]               duration;
    } bpe_cmd_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      level_valid;
        logic [1:0]                status;
    } bpe_res_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]         time_frac;
    } bpe_point_t;

endpackage

FILE: rtl/bpe_if.sv
// Valid/ready channels of the envelope generator: command words in, result words out.
// Depends on bpe_pkg for the payload types.
interface bpe_cmd_if;
    logic               valid;
    logic               ready;
    bpe_pkg::bpe_cmd_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bpe_res_if;
    logic               valid;
    logic               ready;
    bpe_pkg::bpe_res_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/bpe_point_mem.sv
// Breakpoint store: one level and one time per entry, synchronous read.
// Depends on bpe_pkg for the entry type.
module bpe_point_mem #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
) (
    input  logic                clk,
    input  logic                we,
    input  logic [IW-1:0]       waddr,
    input  bpe_pkg::bpe_point_t wdata,
    input  logic [IW-1:0]       raddr,
    output bpe_pkg::bpe_point_t rdata
);
    import bpe_pkg::*;

    bpe_point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/bpe_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module bpe_div #(
    parameter int NW = 40,
    parameter int DW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(NW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift one dividend bit in, subtract where it fits
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        end
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: rtl/bpe_level_mul.sv
// Bit-serial shift-add multiplier for the level offset, with a sticky overflow
// once the product passes the saturation limit. Depends on bpe_pkg.
module bpe_level_mul #(
    parameter int MW = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [MW-1:0]                     multiplier,
    input  logic [bpe_pkg::SLOPE_MAG_W-1:0]   multiplicand,
    output logic                              busy,
    output logic                              done,
    output logic [bpe_pkg::PROD_W-1:0]        product,
    output logic                              overflow
);
    import bpe_pkg::*;

    localparam int CW = $clog2(MW + 1);

    logic [CW-1:0]          cnt_reg;
    logic                   done_reg;
    logic [MW-1:0]          mplr_reg;
    logic [SLOPE_MAG_W-1:0] mcand_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic                   ovf_reg;
    logic [PROD_W:0]        sum;

    assign sum = {acc_reg, 1'b0}
               + (mplr_reg[MW-1] ? (PROD_W+1)'(mcand_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(MW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mplr_reg  <= multiplier;
            mcand_reg <= multiplicand;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            mplr_reg <= {mplr_reg[MW-2:0], 1'b0};
            // past the limit the exact value no longer matters: hold the flag
            if (sum > (PROD_W+1)'(PRODUCT_LIMIT))
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                acc_reg <= sum[PROD_W-1:0];
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign product  = acc_reg;
    assign overflow = ovf_reg;
endmodule

FILE: rtl/breakpoint_envelope_generator.sv
// Breakpoint envelope generator top level: sequencer, config registers, output register.
// Depends on bpe_pkg, bpe_if, bpe_point_mem, bpe_div, bpe_level_mul, assert_macros.svh.
//
// Usage: command words arrive on cmd (valid/ready), one result word per command
// leaves on result. APB writes set point_count (0x0) and spacing_mode (0x4).
// Write breakpoint, unknown operation and exhausted next go from idle straight to emit.
// Next sample: waits on the bit-serial level multiplier, then may load the next segment.
// Begin and each segment change: two table reads, then two position divisions (none in
// stored mode) and one slope division (none for an empty segment) on the shared
// restoring divider (NUMW = max(DURATION_BITS+10, 40) dividend bits); a next sample that
// crosses several empty segments pays this once per segment.
// One command is worked on at a time; cmd.ready is high while the sequencer idles.
// A finished result waits in the output register; while result.ready stays low
// the next command is still taken, and its result holds until the register frees.
// Reset clears counters, segment state and output valid; the breakpoint table is
// not cleared and must be written before it is used.
`include "assert_macros.svh"

module breakpoint_envelope_generator #(
    parameter int MAX_POINTS    = 16,
    parameter int DURATION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    bpe_cmd_if.sink     cmd,
    bpe_res_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpe_pkg::*;

    localparam int DB    = DURATION_BITS;
    localparam int IW    = $clog2(MAX_POINTS);
    localparam int NUMW  = (DB + 10 > 40) ? DB + 10 : 40;
    localparam int DENW  = (DB + 1 > 10) ? DB + 1 : 10;
    localparam int PRODW = TIME_W + DB;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_FAC, S_PROD, S_POSD, S_DIVW,
        S_SLOPE, S_SLOPEW, S_MULW, S_ADV, S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [COUNT_W-1:0]        pc_reg;
    logic [1:0]                mode_reg;
    logic [DB-1:0]             total_reg;
    logic [DB-1:0]             s_reg;
    logic [COUNT_W-1:0]        j_reg;
    logic [DB-1:0]             start_reg;
    logic [DB-1:0]             end_reg;
    logic signed [LEVEL_W-1:0] slev_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic                      sel_next_reg;
    logic                      pos_sel_reg;
    logic signed [LEVEL_W-1:0] v0_reg;
    logic signed [LEVEL_W-1:0] v1_reg;
    logic [TIME_W-1:0]         tt0_reg;
    logic [TIME_W-1:0]         tt1_reg;
    logic [DB-1:0]             t0_reg;
    logic [DB-1:0]             t1_reg;
    logic [TIME_W-1:0]         fac_reg;
    logic [DENW-1:0]           den_reg;
    logic [PRODW-1:0]          prod_reg;
    bpe_res_t                  pend_reg;
    bpe_res_t                  out_reg;
    logic                      out_valid_reg;

    logic                      accept;
    logic                      bad_index;
    logic [COUNT_W-1:0]        n_act;
    logic [COUNT_W-1:0]        m_act;
    logic [COUNT_W-1:0]        j_inc;
    logic [COUNT_W-1:0]        k_sel;
    logic [TIME_W-1:0]         fac_next;
    logic [DENW-1:0]           den_next;
    logic [DB-1:0]             pos_stored;

    logic                      mem_we;
    logic [IW-1:0]             mem_raddr;
    bpe_point_t                mem_wdata;
    bpe_point_t                mem_rdata;

    logic                      div_start;
    logic [NUMW-1:0]           div_num;
    logic [DENW-1:0]           div_den;
    logic                      div_busy;
    logic                      div_done;
    logic [NUMW-1:0]           div_quo;

    logic                      mul_start;
    logic                      mul_busy;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_prod;
    logic                      mul_ovf;

    logic signed [LEVEL_W:0]   dv;
    logic [LEVEL_W-1:0]        dv_mag;
    logic signed [DB:0]        den_seg;
    logic [DB-1:0]             den_mag;
    logic                      slope_neg;
    logic signed [SLOPE_W-1:0] slope_next;

    logic signed [DB:0]        d_off;
    logic [DB-1:0]             ud;
    logic [SLOPE_MAG_W-1:0]    us;
    logic                      lev_neg;
    logic [25:0]               q_mag;
    logic signed [26:0]        q_s;
    logic signed [27:0]        lev_sum;
    logic signed [LEVEL_W-1:0] lev_out;

    // ---- configuration port
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_POINT_COUNT: prdata = {27'b0, pc_reg};
            REG_SPACING:     prdata = {30'b0, mode_reg};
            default:         prdata = '0;
        endcase
    end

    // ---- decode
    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign bad_index = ({28'b0, cmd.payload.point_index} >= MAX_POINTS);

    always_comb
    begin
        if (pc_reg < COUNT_W'(2))
        begin
            n_act = COUNT_W'(2);
        end
        else if ({27'b0, pc_reg} > MAX_POINTS)
        begin
            n_act = COUNT_W'(MAX_POINTS);
        end
        else
        begin
            n_act = pc_reg;
        end
    end

    assign m_act = n_act - 1'b1;
    assign j_inc = j_reg + 1'b1;
    assign k_sel = pos_sel_reg ? j_inc : j_reg;

    always_comb
    begin
        case (mode_reg)
            MODE_EQUAL:
            begin
                fac_next = TIME_W'(k_sel);
                den_next = DENW'(m_act);
            end
            MODE_SLOWDOWN:
            begin
                fac_next = TIME_W'({5'b0, k_sel} * {5'b0, k_sel});
                den_next = DENW'({5'b0, m_act} * {5'b0, m_act});
            end
            MODE_CENTERED:
            begin
                fac_next = TIME_W'({k_sel, 1'b1});
                den_next = DENW'({n_act, 1'b0});
            end
            default:
            begin
                fac_next = pos_sel_reg ? tt1_reg : tt0_reg;
                den_next = DENW'(1);
            end
        endcase
    end

    assign pos_stored = DB'(prod_reg >> 16);

    // ---- breakpoint memory
    assign mem_we              = accept && (cmd.payload.operation == OP_WRITE) && !bad_index;
    assign mem_wdata.level     = cmd.payload.point_value;
    assign mem_wdata.time_frac = (cmd.payload.point_time > TIME_ONE) ? TIME_ONE
                                                                     : cmd.payload.point_time;
    assign mem_raddr           = (state_reg == S_RD1) ? IW'(j_inc) : IW'(j_reg);

    bpe_point_mem #(
        .DEPTH (MAX_POINTS),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (IW'(cmd.payload.point_index)),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // ---- slope operands
    assign dv        = {v1_reg[LEVEL_W-1], v1_reg} - {v0_reg[LEVEL_W-1], v0_reg};
    assign dv_mag    = dv[LEVEL_W] ? LEVEL_W'(-dv) : dv[LEVEL_W-1:0];
    assign den_seg   = {1'b0, t1_reg} - {1'b0, t0_reg};
    assign den_mag   = den_seg[DB] ? DB'(-den_seg) : den_seg[DB-1:0];
    assign slope_neg = dv[LEVEL_W] ^ den_seg[DB];
    assign slope_next = slope_neg ? -$signed({1'b0, div_quo[SLOPE_MAG_W-1:0]})
                                  : $signed({1'b0, div_quo[SLOPE_MAG_W-1:0]});

    // ---- shared divider
    assign div_start = ((state_reg == S_POSD) && (mode_reg != MODE_STORED))
                    || ((state_reg == S_SLOPE) && (den_seg != '0));
    assign div_num   = (state_reg == S_SLOPE) ? NUMW'({dv_mag, 16'b0}) : NUMW'(prod_reg);
    assign div_den   = (state_reg == S_SLOPE) ? DENW'(den_mag) : den_reg;

    bpe_div #(
        .NW (NUMW),
        .DW (DENW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---- level multiplier
    assign d_off   = {1'b0, s_reg} - {1'b0, start_reg};
    assign ud      = d_off[DB] ? DB'(-d_off) : d_off[DB-1:0];
    assign us      = slope_reg[SLOPE_W-1] ? SLOPE_MAG_W'(-slope_reg)
                                          : slope_reg[SLOPE_MAG_W-1:0];
    assign lev_neg = d_off[DB] ^ slope_reg[SLOPE_W-1];
    assign mul_start = accept && (cmd.payload.operation == OP_NEXT) && (s_reg < total_reg);

    bpe_level_mul #(
        .MW (DB)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplier   (ud),
        .multiplicand (us),
        .busy         (mul_busy),
        .done         (mul_done),
        .product      (mul_prod),
        .overflow     (mul_ovf)
    );

    // round toward minus infinity on negative offsets
    assign q_mag   = lev_neg ? 26'(((PROD_W+1)'(mul_prod) + 43'd65535) >> 16)
                             : 26'(mul_prod >> 16);
    assign q_s     = lev_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign lev_sum = {{4{slev_reg[LEVEL_W-1]}}, slev_reg} + {q_s[26], q_s};

    always_comb
    begin
        if (mul_ovf)
        begin
            lev_out = lev_neg ? LEVEL_MIN : LEVEL_MAX;
        end
        else if (lev_sum > 28'sd8388607)
        begin
            lev_out = LEVEL_MAX;
        end
        else if (lev_sum < -28'sd8388608)
        begin
            lev_out = LEVEL_MIN;
        end
        else
        begin
            lev_out = lev_sum[LEVEL_W-1:0];
        end
    end

    // ---- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= COUNT_W'(2);
            mode_reg      <= MODE_EQUAL;
            total_reg     <= '0;
            s_reg         <= '0;
            j_reg         <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            slev_reg      <= '0;
            slope_reg     <= '0;
            sel_next_reg  <= 1'b0;
            pos_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[2])
                    REG_POINT_COUNT: pc_reg   <= pwdata[COUNT_W-1:0];
                    REG_SPACING:     mode_reg <= pwdata[1:0];
                    default:         ;
                endcase
            end

            // drop the word once taken, unless a new one is loaded now
            if (out_valid_reg && result.ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd.payload.operation)
                            OP_WRITE:
                            begin
                                pend_reg  <= '{level: '0, level_valid: 1'b0,
                                               status: bad_index ? ST_BAD_INDEX : ST_OK};
                                state_reg <= S_EMIT;
                            end
                            OP_BEGIN:
                            begin
                                pend_reg     <= '{level: '0, level_valid: 1'b0, status: ST_OK};
                                total_reg    <= DB'(cmd.payload.duration);
                                s_reg        <= '0;
                                j_reg        <= '0;
                                sel_next_reg <= 1'b0;
                                state_reg    <= S_RD0;
                            end
                            OP_NEXT:
                            begin
                                if (s_reg >= total_reg)
                                begin
                                    pend_reg  <= '{level: '0, level_valid: 1'b0,
                                                   status: ST_EMPTY};
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_MULW;
                                end
                            end
                            default:
                            begin
                                pend_reg  <= '{level: '0, level_valid: 1'b0, status: ST_OK};
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    v0_reg    <= mem_rdata.level;
                    tt0_reg   <= mem_rdata.time_frac;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    v1_reg      <= mem_rdata.level;
                    tt1_reg     <= mem_rdata.time_frac;
                    pos_sel_reg <= 1'b0;
                    state_reg   <= S_FAC;
                end
                S_FAC:
                begin
                    fac_reg   <= fac_next;
                    den_reg   <= den_next;
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    prod_reg  <= PRODW'(fac_reg) * PRODW'(total_reg);
                    state_reg <= S_POSD;
                end
                S_POSD:
                begin
                    if (mode_reg == MODE_STORED)
                    begin
                        if (pos_sel_reg)
                        begin
                            t1_reg    <= pos_stored;
                            state_reg <= S_SLOPE;
                        end
                        else
                        begin
                            t0_reg      <= pos_stored;
                            pos_sel_reg <= 1'b1;
                            state_reg   <= S_FAC;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        if (pos_sel_reg)
                        begin
                            t1_reg    <= div_quo[DB-1:0];
                            state_reg <= S_SLOPE;
                        end
                        else
                        begin
                            t0_reg      <= div_quo[DB-1:0];
                            pos_sel_reg <= 1'b1;
                            state_reg   <= S_FAC;
                        end
                    end
                end
                S_SLOPE:
                begin
                    if (den_seg == '0)
                    begin
                        // empty segment: flat line
                        slope_reg <= '0;
                        start_reg <= t0_reg;
                        end_reg   <= t1_reg;
                        slev_reg  <= v0_reg;
                        state_reg <= sel_next_reg ? S_ADV : S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_SLOPEW;
                    end
                end
                S_SLOPEW:
                begin
                    if (div_done)
                    begin
                        slope_reg <= slope_next;
                        start_reg <= t0_reg;
                        end_reg   <= t1_reg;
                        slev_reg  <= v0_reg;
                        state_reg <= sel_next_reg ? S_ADV : S_EMIT;
                    end
                end
                S_MULW:
                begin
                    if (mul_done)
                    begin
                        pend_reg  <= '{level: lev_out, level_valid: 1'b1, status: ST_OK};
                        s_reg     <= s_reg + 1'b1;
                        state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    if ((s_reg >= end_reg) && (({1'b0, j_reg} + 6'd2) < {1'b0, n_act}))
                    begin
                        j_reg        <= j_inc;
                        sel_next_reg <= 1'b1;
                        state_reg    <= S_RD0;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || result.ready)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    `BPE_ASSERT(a_div_idle, clk, rst_n, div_start |-> !div_busy, "divider started while busy")
    `BPE_ASSERT(a_mul_idle, clk, rst_n, mul_start |-> !mul_busy, "multiplier started while busy")
    `BPE_ASSERT(a_emit_quiet, clk, rst_n, (state_reg == S_EMIT) |-> !(div_busy || mul_busy), "arithmetic unit busy at emit")
    `BPE_ASSERT_ALWAYS(a_one_unit, clk, !(div_start && mul_start), "divider and multiplier started together")
endmodule
